FILE: src/json_string_escaper_unit_macros.svh
// assertion macros for the json string escaper unit
// used by the top level only; no other dependencies
`ifndef JSON_STRING_ESCAPER_UNIT_MACROS_SVH
`define JSON_STRING_ESCAPER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, muted while reset is high
`define JSEU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("json string escaper check failed");
// checked property, also checked during reset
`define JSEU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("json string escaper check failed");
`else
`define JSEU_ASSERT(label, clk, rst, prop)
`define JSEU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: src/jse_pkg.sv
// shared types, constants and helpers for the json string escaper
// no dependencies
package jse_pkg;

   localparam int CAP_W = 17;
   localparam logic [CAP_W-1:0] MAX_CAPACITY = 17'd65536;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;
   localparam logic [QCNT_W-1:0] QUEUE_FULL_COUNT = 3'd4;

   localparam int LEN_W = 3;
   localparam logic [LEN_W-1:0] PASS_LEN = 3'd1;
   localparam logic [LEN_W-1:0] SHORT_LEN = 3'd2;
   localparam logic [LEN_W-1:0] UNI_LEN = 3'd6;
   localparam logic [LEN_W-1:0] TERM_LEN = 3'd1;

   localparam logic [7:0] CTRL_LIMIT = 8'h20;
   localparam logic [7:0] DEL_CHAR = 8'h7F;
   localparam logic [7:0] NUL_CHAR = 8'h00;
   localparam logic [7:0] BSLASH_CHAR = 8'h5C;
   localparam logic [7:0] QUOTE_CHAR = 8'h22;
   localparam logic [7:0] BS_CHAR = 8'h08;
   localparam logic [7:0] FF_CHAR = 8'h0C;
   localparam logic [7:0] LF_CHAR = 8'h0A;
   localparam logic [7:0] CR_CHAR = 8'h0D;
   localparam logic [7:0] TAB_CHAR = 8'h09;
   localparam logic [7:0] U_CHAR = 8'h75;
   localparam logic [7:0] ZERO_CHAR = 8'h30;
   localparam logic [7:0] B_CHAR = 8'h62;
   localparam logic [7:0] F_CHAR = 8'h66;
   localparam logic [7:0] N_CHAR = 8'h6E;
   localparam logic [7:0] R_CHAR = 8'h72;
   localparam logic [7:0] T_CHAR = 8'h74;

   // how the back part expands one queued piece
   typedef enum logic [1:0] {
      KIND_PASS  = 2'b00,
      KIND_SHORT = 2'b01,
      KIND_UNI   = 2'b10,
      KIND_TERM  = 2'b11
   } piece_kind_type;

   typedef struct packed {
      piece_kind_type kind;
      logic [7:0]     data;      // raw byte, escape letter or unused
      logic           complete;  // terminator only
   } piece_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] wide;
      wide = {4'h0, v};
      if (v < 4'd10) begin
         return wide + ZERO_CHAR;
      end
      return wide + 8'h57;
   endfunction

endpackage

FILE: src/jse_front.sv
// front part: capacity register, byte classification and fit check
// depends on jse_pkg
module jse_front import jse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_capacity,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  queue_status_type q_status,
   output logic             q_push,
   output piece_type        q_piece
);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CAP_W-1:0] written_ff, written_in;
   logic             truncated_ff, truncated_in;

   logic             accept;
   piece_kind_type   kind;
   logic [7:0]       letter;
   logic [LEN_W-1:0] len;
   logic [CAP_W:0]   sum;
   logic             fits;

   assign csr_ready = 1'b1;
   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;

   // classify
   always_comb begin
      kind = KIND_PASS;
      letter = req_in_byte;
      unique case (req_in_byte)
         QUOTE_CHAR:  begin kind = KIND_SHORT; letter = QUOTE_CHAR; end
         BSLASH_CHAR: begin kind = KIND_SHORT; letter = BSLASH_CHAR; end
         BS_CHAR:     begin kind = KIND_SHORT; letter = B_CHAR; end
         FF_CHAR:     begin kind = KIND_SHORT; letter = F_CHAR; end
         LF_CHAR:     begin kind = KIND_SHORT; letter = N_CHAR; end
         CR_CHAR:     begin kind = KIND_SHORT; letter = R_CHAR; end
         TAB_CHAR:    begin kind = KIND_SHORT; letter = T_CHAR; end
         default: begin
            if (req_in_byte < CTRL_LIMIT || req_in_byte == DEL_CHAR) begin
               kind = KIND_UNI;
            end
         end
      endcase
   end

   always_comb begin
      unique case (kind)
         KIND_SHORT: len = SHORT_LEN;
         KIND_UNI:   len = UNI_LEN;
         default:    len = PASS_LEN;
      endcase
   end

   assign sum = {1'b0, written_ff} + {{(CAP_W+1-LEN_W){1'b0}}, len};
   assign fits = sum < {1'b0, capacity_ff};

   always_comb begin
      capacity_in = capacity_ff;
      written_in = written_ff;
      truncated_in = truncated_ff;
      q_push = 1'b0;
      q_piece.kind = kind;
      q_piece.data = letter;
      q_piece.complete = 1'b0;
      if (csr_valid) begin
         capacity_in = (csr_capacity > MAX_CAPACITY) ? MAX_CAPACITY : csr_capacity;
      end
      if (accept) begin
         if (req_in_byte == NUL_CHAR) begin
            q_push = 1'b1;
            q_piece.kind = KIND_TERM;
            q_piece.data = NUL_CHAR;
            q_piece.complete = !truncated_ff;
            written_in = '0;
            truncated_in = 1'b0;
         end else if (!truncated_ff) begin
            if (fits) begin
               q_push = 1'b1;
               written_in = sum[CAP_W-1:0];
            end else begin
               truncated_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= MAX_CAPACITY;
         written_ff <= '0;
         truncated_ff <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         written_ff <= written_in;
         truncated_ff <= truncated_in;
      end
   end

endmodule

FILE: src/jse_fifo.sv
// small queue of classified pieces between front and back
// depends on jse_pkg
module jse_fifo import jse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  piece_type        push_piece,
   input  logic             pop,
   output piece_type        head,
   output queue_status_type status
);

   piece_type         entry_ff [QUEUE_DEPTH];
   piece_type         entry_in;
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head = entry_ff[rd_ptr_ff];
   assign status.full = count_ff == QUEUE_FULL_COUNT;
   assign status.empty = count_ff == '0;
   assign entry_in = push_piece;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/jse_back.sv
// back part: expands one piece into 1, 2 or 6 result items
// depends on jse_pkg
module jse_back import jse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  piece_type        head,
   input  queue_status_type q_status,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_end_of_text,
   output logic             rsp_complete
);

   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       char_ff, char_in;
   logic             eot_ff, eot_in;
   logic             comp_ff, comp_in;

   logic             load;
   logic [LEN_W-1:0] len;
   logic             last;
   logic [7:0]       next_char;

   assign load = !q_status.empty && (!valid_ff || rsp_ready);

   always_comb begin
      next_char = head.data;
      unique case (head.kind)
         KIND_PASS:  begin len = PASS_LEN; next_char = head.data; end
         KIND_TERM:  begin len = TERM_LEN; next_char = NUL_CHAR; end
         KIND_SHORT: begin
            len = SHORT_LEN;
            next_char = (idx_ff == '0) ? BSLASH_CHAR : head.data;
         end
         KIND_UNI: begin
            len = UNI_LEN;
            case (idx_ff)
               3'd0:    next_char = BSLASH_CHAR;
               3'd1:    next_char = U_CHAR;
               3'd4:    next_char = hex_digit(head.data[7:4]);
               3'd5:    next_char = hex_digit(head.data[3:0]);
               default: next_char = ZERO_CHAR;
            endcase
         end
         default: begin len = PASS_LEN; next_char = head.data; end
      endcase
   end

   assign last = idx_ff == (len - 1'b1);
   assign q_pop = load && last;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      char_in = char_ff;
      eot_in = eot_ff;
      comp_in = comp_ff;
      if (load) begin
         valid_in = 1'b1;
         char_in = next_char;
         eot_in = head.kind == KIND_TERM;
         comp_in = (head.kind == KIND_TERM) && head.complete;
         idx_in = last ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      eot_ff <= eot_in;
      comp_ff <= comp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_end_of_text = eot_ff;
   assign rsp_complete = comp_ff;

endmodule

FILE: src/json_string_escaper_unit.sv
// json string escaper: one string byte in, its escaped form out, one byte per item
// a byte's first result item is registered in the queue, then in the output register
// throughput: 1 input item per cycle for plain bytes while the queue is not full;
//   the output register sends one byte per cycle while rsp_ready is high
// reset: output count and truncation flag clear, capacity goes to 65536, queue empties
`include "json_string_escaper_unit_macros.svh"
module json_string_escaper_unit import jse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // configuration write: capacity in bytes, terminator included
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_capacity,
   // input bytes
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   // escaped output bytes
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_end_of_text,
   output logic             rsp_complete
);

   // front to queue
   logic             q_push;
   piece_type        q_piece;
   // queue to back
   logic             q_pop;
   piece_type        q_head;
   queue_status_type q_status;

   // front: holds capacity and the running count, classifies each byte and decides
   // whether its whole piece still fits; dropped bytes are accepted but never queued
   jse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_capacity (csr_capacity),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_piece      (q_piece)
   );

   // four-entry queue lets the front keep taking bytes while an escape drains
   jse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_piece (q_piece),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // back: walks each piece a byte at a time into the output register
   jse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_complete    (rsp_complete)
   );

   // front never pushes into a full queue
   `JSEU_ASSERT(a_no_overflow, clock, reset, q_push |-> !q_status.full)
   // back never pops an empty queue
   `JSEU_ASSERT_ALWAYS(a_no_underflow, clock, q_pop |-> !q_status.empty)
   // an end of string byte is always queued as a terminator
   `JSEU_ASSERT(a_term_queued, clock, reset,
      (req_valid && req_ready && req_in_byte == NUL_CHAR) |=> !q_status.empty)
   // complete only ever rides on the terminator, which carries a zero byte
   `JSEU_ASSERT(a_term_shape, clock, reset,
      (rsp_valid && rsp_complete) |-> (rsp_end_of_text && rsp_out_char == NUL_CHAR))

endmodule
